// File: design/ppd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants for the position PID controller
// Field widths, item structs, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package ppd_pkg;

	// field and datapath widths
	localparam int POS_W     = 32;
	localparam int CFG_W     = 16;
	localparam int DRIVE_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int ERR_W     = 32;
	localparam int INTEG_W   = 24;
	localparam int ISUM_W    = 34;
	localparam int DERIV_W   = 33;
	localparam int ILIM_W    = 23;
	localparam int PTERM_W   = 49;
	localparam int DTERM_W   = 50;
	localparam int IQ_W      = 17;
	localparam int ITERM_W   = 33;
	localparam int SUM_W     = 51;

	// pid scale and deadband
	localparam int PID_SCALE = 100;
	localparam logic signed [ERR_W-1:0] DEADBAND = 32'sd2;

	// divide by 100 through a reciprocal, exact for values below 2^23
	localparam int RECIP_W  = 24;
	localparam int RECIP_SH = 30;
	localparam int PROD_W   = ILIM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;

	// register reset values
	localparam logic [CFG_W-1:0] KP_RESET     = 16'd100;
	localparam logic [CFG_W-1:0] KI_RESET     = 16'd0;
	localparam logic [CFG_W-1:0] KD_RESET     = 16'd0;
	localparam logic [CFG_W-1:0] OLIM_RESET   = 16'd0;
	localparam logic [CFG_W-1:0] DMAX_RESET   = 16'hFFFF;
	localparam logic [CFG_W-1:0] DSTART_RESET = 16'd0;
	localparam logic [ILIM_W-1:0] ILIM_RESET  = ILIM_W'(int'(DMAX_RESET) * PID_SCALE);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_GAIN      = 3'd0,
		REG_KI_GAIN      = 3'd1,
		REG_KD_GAIN      = 3'd2,
		REG_OUTPUT_LIMIT = 3'd3,
		REG_DRIVE_MAX    = 3'd4,
		REG_DRIVE_START  = 3'd5
	} ppd_reg_t;

	// input item
	typedef struct packed {
		logic signed [POS_W-1:0] target_position;
		logic signed [POS_W-1:0] current_position;
		logic                    restart;
	} ppd_in_t;

	// result item
	typedef struct packed {
		logic               direction;
		logic [DRIVE_W-1:0] drive;
	} ppd_out_t;

endpackage
`default_nettype wire

// File: design/ppd_meas_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_meas_if: input channel of the position PID controller
// Valid/ready channel carrying target, measured position and restart flag.
// ----------------------------------------------------------------------------
interface ppd_meas_if;
	logic             valid;
	logic             ready;
	ppd_pkg::ppd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/ppd_ctrl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_ctrl_if: result channel of the position PID controller
// Valid/ready channel carrying direction and drive magnitude.
// ----------------------------------------------------------------------------
interface ppd_ctrl_if;
	logic              valid;
	logic              ready;
	ppd_pkg::ppd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/position_pid_with_deadband.sv
`default_nettype none
// ----------------------------------------------------------------------------
// position_pid_with_deadband: position PID with anti-windup and deadband
// Nine-stage pipeline: error, integrator update, gain products, sum,
// divide by 100 with clip, cap, deadband and start minimum.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | handshake
//  ---------+-----+----------------------------------------------+----------
//  meas     | in  | target_position, current_position, restart   | valid/ready
//  ctrl     | out | direction, drive                             | valid/ready
//  cfg      | in  | cfg_wr_en, cfg_index, cfg_data               | write only
//
//  one item per cycle sustained while ctrl.ready is held; nine register stages
//  lie between an accepted input item and its result on ctrl
//  the integrator and last-error registers close their loop in stage 3 only
//  each stage holds while the next is full and stalled; bubbles collapse
//  reset clears gains/limits to defaults and the integrator state to zero
// ----------------------------------------------------------------------------
module position_pid_with_deadband (
	input  wire                              clk,
	input  wire                              arst_n,
	ppd_meas_if.sink                         meas,
	ppd_ctrl_if.source                       ctrl,
	input  wire                              cfg_wr_en,
	input  wire [ppd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [ppd_pkg::CFG_W-1:0]         cfg_data
);

	localparam int NSTG = 9;

	// configuration registers
	logic [ppd_pkg::CFG_W-1:0]  kp_q, ki_q, kd_q, olim_q, dmax_q, dstart_q;
	logic [ppd_pkg::CFG_W-1:0]  lim_q;
	logic [ppd_pkg::ILIM_W-1:0] ilim_q;
	logic [ppd_pkg::CFG_W-1:0]  lim_d;

	// controller state
	logic signed [ppd_pkg::INTEG_W-1:0] integ_q;
	logic signed [ppd_pkg::ERR_W-1:0]   prev_q;

	// pipeline control
	logic [NSTG:1] vld_q;
	logic [NSTG:1] rdy;

	// stage registers
	logic signed [ppd_pkg::POS_W-1:0]   tgt_s1, cur_s1;
	logic                               rst_s1;
	logic signed [ppd_pkg::ERR_W-1:0]   err_s2;
	logic                               rst_s2;
	logic signed [ppd_pkg::ERR_W-1:0]   err_s3;
	logic signed [ppd_pkg::INTEG_W-1:0] integ_s3;
	logic signed [ppd_pkg::DERIV_W-1:0] deriv_s3;
	logic                               dead_s3;
	logic signed [ppd_pkg::PTERM_W-1:0] pterm_s4, pterm_s5;
	logic signed [ppd_pkg::DTERM_W-1:0] dterm_s4, dterm_s5;
	logic [ppd_pkg::PROD_W-1:0]         iprod_s4;
	logic                               ineg_s4, dead_s4, dead_s5;
	logic signed [ppd_pkg::ITERM_W-1:0] iterm_s5;
	logic signed [ppd_pkg::SUM_W-1:0]   sum_s6;
	logic                               dead_s6;
	logic                               neg_s7, sat_s7, dead_s7;
	logic [ppd_pkg::ILIM_W-1:0]         small_s7;
	logic [ppd_pkg::PROD_W-1:0]         prod_s8;
	logic                               neg_s8, sat_s8, dead_s8;
	logic                               dir_s9;
	logic [ppd_pkg::DRIVE_W-1:0]        drive_s9;

	// combinational stage values
	logic signed [ppd_pkg::DERIV_W-1:0] diff;
	logic signed [ppd_pkg::ERR_W-1:0]   err_d;
	logic signed [ppd_pkg::INTEG_W-1:0] integ_eff, integ_new;
	logic signed [ppd_pkg::ERR_W-1:0]   prev_eff;
	logic signed [ppd_pkg::ISUM_W-1:0]  isum, ilim_x;
	logic signed [ppd_pkg::DERIV_W-1:0] deriv_d;
	logic                               dead_d;
	logic signed [ppd_pkg::PTERM_W-1:0] kp_x, errp_x;
	logic signed [ppd_pkg::DTERM_W-1:0] kd_x, der_x;
	logic signed [ppd_pkg::INTEG_W-1:0] integ_abs;
	logic signed [ppd_pkg::ITERM_W-1:0] ki_x, iq_x;
	logic [ppd_pkg::IQ_W-1:0]           iq;
	logic [ppd_pkg::SUM_W-1:0]          mag;
	logic [ppd_pkg::DRIVE_W-1:0]        q9, clip9, cap9, drv9;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= ppd_pkg::KP_RESET;
			ki_q     <= ppd_pkg::KI_RESET;
			kd_q     <= ppd_pkg::KD_RESET;
			olim_q   <= ppd_pkg::OLIM_RESET;
			dmax_q   <= ppd_pkg::DMAX_RESET;
			dstart_q <= ppd_pkg::DSTART_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ppd_pkg::REG_KP_GAIN:      kp_q     <= cfg_data;
				ppd_pkg::REG_KI_GAIN:      ki_q     <= cfg_data;
				ppd_pkg::REG_KD_GAIN:      kd_q     <= cfg_data;
				ppd_pkg::REG_OUTPUT_LIMIT: olim_q   <= cfg_data;
				ppd_pkg::REG_DRIVE_MAX:    dmax_q   <= cfg_data;
				ppd_pkg::REG_DRIVE_START:  dstart_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective limit and integral bound
	assign lim_d = (olim_q == '0) ? dmax_q : olim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= ppd_pkg::DMAX_RESET;
			ilim_q <= ppd_pkg::ILIM_RESET;
		end else begin
			lim_q  <= lim_d;
			ilim_q <= ppd_pkg::ILIM_W'(lim_d) * ppd_pkg::ILIM_W'(ppd_pkg::PID_SCALE);
		end
	end

	// stage enables: a stage loads when empty or when its item moves on
	always_comb begin
		rdy[NSTG] = !vld_q[NSTG] || ctrl.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= meas.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign meas.ready = rdy[1];
	assign ctrl.valid = vld_q[NSTG];
	assign ctrl.data  = '{direction: dir_s9, drive: drive_s9};

	// stage 2: saturated position error
	always_comb begin
		diff = ppd_pkg::DERIV_W'(tgt_s1) - ppd_pkg::DERIV_W'(cur_s1);
		if (diff[ppd_pkg::DERIV_W-1] != diff[ppd_pkg::ERR_W-1]) begin
			err_d = diff[ppd_pkg::DERIV_W-1] ? {1'b1, {(ppd_pkg::ERR_W-1){1'b0}}}
			                                 : {1'b0, {(ppd_pkg::ERR_W-1){1'b1}}};
		end else begin
			err_d = diff[ppd_pkg::ERR_W-1:0];
		end
	end

	// stage 3: integrator with clamp, derivative, deadband test
	always_comb begin
		integ_eff = rst_s2 ? '0 : integ_q;
		prev_eff  = rst_s2 ? '0 : prev_q;
		isum      = ppd_pkg::ISUM_W'(integ_eff) + ppd_pkg::ISUM_W'(err_s2);
		ilim_x    = ppd_pkg::ISUM_W'(ilim_q);
		if (isum > ilim_x) begin
			integ_new = ppd_pkg::INTEG_W'(ilim_x);
		end else if (isum < -ilim_x) begin
			integ_new = ppd_pkg::INTEG_W'(-ilim_x);
		end else begin
			integ_new = ppd_pkg::INTEG_W'(isum);
		end
		deriv_d = ppd_pkg::DERIV_W'(err_s2) - ppd_pkg::DERIV_W'(prev_eff);
		dead_d  = (err_s2 <= ppd_pkg::DEADBAND) && (err_s2 >= -ppd_pkg::DEADBAND);
	end

	// integrator state follows each item entering stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (rdy[3] && vld_q[2]) begin
			integ_q <= dead_d ? '0 : integ_new;
			prev_q  <= err_s2;
		end
	end

	// stage 4: proportional and derivative products, integral reciprocal
	always_comb begin
		kp_x      = ppd_pkg::PTERM_W'(kp_q);
		errp_x    = ppd_pkg::PTERM_W'(err_s3);
		kd_x      = ppd_pkg::DTERM_W'(kd_q);
		der_x     = ppd_pkg::DTERM_W'(deriv_s3);
		integ_abs = integ_s3[ppd_pkg::INTEG_W-1] ? -integ_s3 : integ_s3;
	end

	// stage 5: integral term from the truncated quotient
	always_comb begin
		iq   = iprod_s4[ppd_pkg::RECIP_SH +: ppd_pkg::IQ_W];
		ki_x = ppd_pkg::ITERM_W'(ki_q);
		iq_x = ineg_s4 ? -ppd_pkg::ITERM_W'(iq) : ppd_pkg::ITERM_W'(iq);
	end

	// stage 7: magnitude of the sum against the clip bound
	assign mag = sum_s6[ppd_pkg::SUM_W-1] ? ppd_pkg::SUM_W'(-sum_s6)
	                                      : ppd_pkg::SUM_W'(sum_s6);

	// stage 9: clip, cap, deadband and start minimum
	always_comb begin
		q9    = prod_s8[ppd_pkg::RECIP_SH +: ppd_pkg::DRIVE_W];
		clip9 = sat_s8 ? lim_q : q9;
		cap9  = (clip9 > dmax_q) ? dmax_q : clip9;
		if (dead_s8) begin
			drv9 = '0;
		end else if (cap9 < dstart_q) begin
			drv9 = dstart_q;
		end else begin
			drv9 = cap9;
		end
	end

	// stage payload registers
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			tgt_s1 <= meas.data.target_position;
			cur_s1 <= meas.data.current_position;
			rst_s1 <= meas.data.restart;
		end
		if (rdy[2]) begin
			err_s2 <= err_d;
			rst_s2 <= rst_s1;
		end
		if (rdy[3]) begin
			err_s3   <= err_s2;
			integ_s3 <= integ_new;
			deriv_s3 <= deriv_d;
			dead_s3  <= dead_d;
		end
		if (rdy[4]) begin
			pterm_s4 <= kp_x * errp_x;
			dterm_s4 <= kd_x * der_x;
			iprod_s4 <= ppd_pkg::PROD_W'(integ_abs) * ppd_pkg::PROD_W'(ppd_pkg::RECIP);
			ineg_s4  <= integ_s3[ppd_pkg::INTEG_W-1];
			dead_s4  <= dead_s3;
		end
		if (rdy[5]) begin
			pterm_s5 <= pterm_s4;
			dterm_s5 <= dterm_s4;
			iterm_s5 <= ki_x * iq_x;
			dead_s5  <= dead_s4;
		end
		if (rdy[6]) begin
			sum_s6  <= ppd_pkg::SUM_W'(pterm_s5) + ppd_pkg::SUM_W'(dterm_s5)
			         + ppd_pkg::SUM_W'(iterm_s5);
			dead_s6 <= dead_s5;
		end
		if (rdy[7]) begin
			neg_s7   <= sum_s6[ppd_pkg::SUM_W-1];
			sat_s7   <= mag >= ppd_pkg::SUM_W'(ilim_q);
			small_s7 <= mag[ppd_pkg::ILIM_W-1:0];
			dead_s7  <= dead_s6;
		end
		if (rdy[8]) begin
			prod_s8 <= ppd_pkg::PROD_W'(small_s7) * ppd_pkg::PROD_W'(ppd_pkg::RECIP);
			neg_s8  <= neg_s7;
			sat_s8  <= sat_s7;
			dead_s8 <= dead_s7;
		end
		if (rdy[9]) begin
			dir_s9   <= neg_s8 && (clip9 != '0);
			drive_s9 <= drv9;
		end
	end

`ifndef ASSERT_OFF
	// an item inside the deadband leaves the integrator cleared
	a_dead_clears_integ: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy[3] && vld_q[2] && dead_d) |=> (integ_q == '0))
		else $error("integrator not cleared inside deadband");

	// a stalled integrator stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[3] && !rdy[3]) |=> (vld_q[3] && $stable(integ_s3) && $stable(err_s3)))
		else $error("stage 3 item changed while stalled");

	// drive above the cap can only come from the start minimum
	a_cap_or_start: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTG] && (drive_s9 > dmax_q)) |-> (drive_s9 == dstart_q))
		else $error("drive exceeds cap without start minimum");
`endif

endmodule
`default_nettype wire
